// File: src/nearest_centroid_confusion_counter_assert.svh
// assertion helpers for the nearest centroid confusion counter
`ifndef NEAREST_CENTROID_CONFUSION_COUNTER_ASSERT_SVH
`define NEAREST_CENTROID_CONFUSION_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define NCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ncc_pkg.sv
`default_nettype none

package ncc_pkg;

    localparam int NUM_CLASSES  = 6;
    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = 16;
    localparam int CLASS_BITS   = 3;
    localparam int DIST_BITS    = 26;
    localparam int SQ_BITS      = 2 * SAMPLE_BITS;
    localparam int CENT_BITS    = 3 * SAMPLE_BITS;
    localparam int CELLS        = NUM_CLASSES * NUM_CLASSES;
    localparam int ADDR_BITS    = $clog2(CELLS);
    localparam int NUM_PAIRS    = (NUM_CLASSES + 1) / 2;
    localparam int PADDR_BITS   = 6;
    localparam int PDATA_BITS   = 64;
    localparam int REG_SEL_LSB  = 3;
    localparam int REG_IDX_BITS = PADDR_BITS - REG_SEL_LSB;

    typedef logic [CENT_BITS-1:0] t_centroid;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_READ     = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]            op;
        logic [CLASS_BITS-1:0] row;
        logic [CLASS_BITS-1:0] col;
    } t_tag;

    typedef struct packed {
        t_tag                  tag;
        logic [CLASS_BITS-1:0] pred;
        logic [DIST_BITS-1:0]  dist_sq;
    } t_job;

    typedef enum logic {
        BS_IDLE,
        BS_UPDATE
    } t_back_state;

endpackage

`default_nettype wire

// File: src/ncc_regs.sv
`default_nettype none

module ncc_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ncc_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [ncc_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [ncc_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    output ncc_pkg::t_centroid                 o_centroid [ncc_pkg::NUM_CLASSES]
);
    import ncc_pkg::*;

    t_centroid               r_cent [NUM_CLASSES];
    logic [REG_IDX_BITS-1:0] w_sel;
    logic                    w_sel_ok;
    logic                    w_wr;

    assign w_sel    = paddr[PADDR_BITS-1:REG_SEL_LSB];
    assign w_sel_ok = (w_sel < REG_IDX_BITS'(NUM_CLASSES));
    assign w_wr     = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cent[k] <= '0;
            end
        end else if (w_wr && w_sel_ok) begin
            r_cent[w_sel] <= pwdata[CENT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_ok) begin
            prdata = PDATA_BITS'(r_cent[w_sel]);
        end
    end

    assign o_centroid = r_cent;

endmodule

`default_nettype wire

// File: src/ncc_front.sv
`default_nettype none

module ncc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ncc_pkg::t_centroid              i_centroid [ncc_pkg::NUM_CLASSES],
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ncc_pkg::t_tag                   i_tag,
    input  logic [ncc_pkg::SAMPLE_BITS-1:0] i_sample_x,
    input  logic [ncc_pkg::SAMPLE_BITS-1:0] i_sample_y,
    input  logic [ncc_pkg::SAMPLE_BITS-1:0] i_sample_z,
    output logic                            o_push,
    input  logic                            i_full,
    output ncc_pkg::t_job                   o_job
);
    import ncc_pkg::*;

    logic [SAMPLE_BITS-1:0] w_samp [3];
    logic [SAMPLE_BITS-1:0] w_diff [NUM_CLASSES][3];
    logic                   w_adv;

    logic [SQ_BITS-1:0]     r_sq   [NUM_CLASSES][3];
    logic [DIST_BITS-1:0]   r_dist [NUM_CLASSES];
    logic [DIST_BITS-1:0]   r_pd   [NUM_PAIRS];
    logic [CLASS_BITS-1:0]  r_pi   [NUM_PAIRS];
    t_tag                   r_tag1, r_tag2, r_tag3;
    logic                   r_v1, r_v2, r_v3;

    logic [DIST_BITS-1:0]   w_best_d;
    logic [CLASS_BITS-1:0]  w_best_i;

    // whole pipe moves together; last stage drains into the queue
    assign w_adv   = !r_v3 || !i_full;
    assign o_ready = w_adv;
    assign o_push  = r_v3 && !i_full;

    assign w_samp[0] = i_sample_x;
    assign w_samp[1] = i_sample_y;
    assign w_samp[2] = i_sample_z;

    always_comb begin
        logic [SAMPLE_BITS-1:0] v_c;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            for (int a = 0; a < 3; a++) begin
                v_c = i_centroid[k][a*SAMPLE_BITS +: SAMPLE_BITS];
                w_diff[k][a] = (w_samp[a] >= v_c) ? (w_samp[a] - v_c) : (v_c - w_samp[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1 squares, stage 2 per-class distance
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_sq[k][a] <= SQ_BITS'(w_diff[k][a]) * SQ_BITS'(w_diff[k][a]);
                end
                r_dist[k] <= DIST_BITS'(r_sq[k][0]) + DIST_BITS'(r_sq[k][1])
                           + DIST_BITS'(r_sq[k][2]);
            end
        end
    end

    // stage 3 pairwise minimum, lower index kept on a tie
    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
        if (2 * p + 1 < NUM_CLASSES) begin : g_two
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (r_dist[2*p+1] < r_dist[2*p]) begin
                        r_pd[p] <= r_dist[2*p+1];
                        r_pi[p] <= CLASS_BITS'(2 * p + 1);
                    end else begin
                        r_pd[p] <= r_dist[2*p];
                        r_pi[p] <= CLASS_BITS'(2 * p);
                    end
                end
            end
        end else begin : g_one
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_pd[p] <= r_dist[2*p];
                    r_pi[p] <= CLASS_BITS'(2 * p);
                end
            end
        end
    end

    always_comb begin
        w_best_d = r_pd[0];
        w_best_i = r_pi[0];
        for (int p = 1; p < NUM_PAIRS; p++) begin
            if (r_pd[p] < w_best_d) begin
                w_best_d = r_pd[p];
                w_best_i = r_pi[p];
            end
        end
    end

    assign o_job.tag     = r_tag3;
    assign o_job.pred    = w_best_i;
    assign o_job.dist_sq = w_best_d;

endmodule

`default_nettype wire

// File: src/ncc_fifo.sv
`default_nettype none

module ncc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ncc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output ncc_pkg::t_job o_job,
    output logic          o_empty
);
    import ncc_pkg::*;

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    t_job                r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (PTR_BITS+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: src/ncc_back.sv
`default_nettype none

module ncc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  ncc_pkg::t_job                   i_job,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ncc_pkg::CLASS_BITS-1:0]  o_pred_class,
    output logic [ncc_pkg::DIST_BITS-1:0]   o_min_distance_sq,
    output logic [ncc_pkg::COUNT_BITS-1:0]  o_cell_count,
    output logic                            o_bad_class
);
    import ncc_pkg::*;

    t_back_state           r_state, n_state;
    logic [COUNT_BITS-1:0] r_mem [CELLS];
    logic [CELLS-1:0]      r_live;
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  r_rlive;
    t_job                  r_job;
    logic [ADDR_BITS-1:0]  r_addr;

    logic                  r_out_vld;
    logic [CLASS_BITS-1:0] r_out_pred;
    logic [DIST_BITS-1:0]  r_out_dist;
    logic [COUNT_BITS-1:0] r_out_cell;
    logic                  r_out_bad;

    logic [CLASS_BITS-1:0] w_head_col;
    logic                  w_head_ok;
    logic [ADDR_BITS-1:0]  w_head_addr;
    logic                  w_can_take;
    logic                  w_pop;
    logic                  w_finish;
    logic                  w_row_ok;
    logic                  w_col_ok;
    logic [COUNT_BITS-1:0] w_cur;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_wr_en;
    logic                  w_clear;
    logic [CLASS_BITS-1:0] w_pred;
    logic [DIST_BITS-1:0]  w_dist;
    logic [COUNT_BITS-1:0] w_cell;
    logic                  w_bad;

    // counter address of the request at the queue head
    assign w_head_col  = (i_job.tag.op == OP_CLASSIFY) ? i_job.pred : i_job.tag.col;
    assign w_head_ok   = (i_job.tag.row < CLASS_BITS'(NUM_CLASSES))
                      && (w_head_col < CLASS_BITS'(NUM_CLASSES));
    assign w_head_addr = ADDR_BITS'(32'(i_job.tag.row) * NUM_CLASSES + 32'(w_head_col));
    assign w_can_take  = !i_empty && (!r_out_vld || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (w_can_take) begin
                    n_state = BS_UPDATE;
                end
            end
            BS_UPDATE: n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        w_pop    = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            BS_IDLE:   w_pop    = w_can_take;
            BS_UPDATE: w_finish = 1'b1;
            default: begin
                w_pop    = 1'b0;
                w_finish = 1'b0;
            end
        endcase
    end

    assign o_pop = w_pop;

    // a cell not written since reset or the last clear reads as zero
    assign w_row_ok = (r_job.tag.row < CLASS_BITS'(NUM_CLASSES));
    assign w_col_ok = (r_job.tag.col < CLASS_BITS'(NUM_CLASSES));
    assign w_cur    = r_rlive ? r_rdata : '0;
    assign w_inc    = (w_cur == '1) ? w_cur : (w_cur + COUNT_BITS'(1));

    always_comb begin
        w_wr_en = 1'b0;
        w_clear = 1'b0;
        w_pred  = '0;
        w_dist  = '0;
        w_cell  = '0;
        w_bad   = 1'b0;
        case (r_job.tag.op)
            OP_CLASSIFY: begin
                w_pred = r_job.pred;
                w_dist = r_job.dist_sq;
                if (w_row_ok) begin
                    w_wr_en = w_finish;
                    w_cell  = w_inc;
                end else begin
                    w_bad = 1'b1;
                end
            end
            OP_CLEAR: w_clear = w_finish;
            OP_READ: begin
                if (!w_row_ok) begin
                    w_bad = 1'b1;
                end else if (w_col_ok) begin
                    w_cell = w_cur;
                end
            end
            default: begin
                w_wr_en = 1'b0;
                w_clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_live    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_live <= '0;
            end else if (w_wr_en) begin
                r_live[r_addr] <= 1'b1;
            end
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_job  <= i_job;
            r_addr <= w_head_addr;
        end
        if (w_pop && w_head_ok) begin
            r_rdata <= r_mem[w_head_addr];
            r_rlive <= r_live[w_head_addr];
        end
        if (w_wr_en) begin
            r_mem[r_addr] <= w_inc;
        end
        if (w_finish) begin
            r_out_pred <= w_pred;
            r_out_dist <= w_dist;
            r_out_cell <= w_cell;
            r_out_bad  <= w_bad;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_pred_class      = r_out_pred;
    assign o_min_distance_sq = r_out_dist;
    assign o_cell_count      = r_out_cell;
    assign o_bad_class       = r_out_bad;

endmodule

`default_nettype wire

// File: src/nearest_centroid_confusion_counter.sv
`default_nettype none

// channel   direction  handshake                    payload
// request   in         i_in_valid / o_in_ready      i_op, i_sample_x/y/z, i_true_class,
//                                                   i_read_column
// result    out        o_out_valid / i_out_ready    o_pred_class, o_min_distance_sq,
//                                                   o_cell_count, o_bad_class
// config    in         psel/penable/pwrite, pready  paddr, pwdata, prdata (centroid i at 8*i)
//
// the distance pipe takes a request every cycle while it is not stalled by a full queue
// the counter stage reads, then updates the counter memory per request, and takes no new
// request until that update is done and the output is free; four requests queue in between
// reset is synchronous, active low: clears centroids, counters and all control state
// a stalled result holds in the output register while the front keeps filling the queue

module nearest_centroid_confusion_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ncc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [ncc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [ncc_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [ncc_pkg::SAMPLE_BITS-1:0] i_sample_x,
    input  logic [ncc_pkg::SAMPLE_BITS-1:0] i_sample_y,
    input  logic [ncc_pkg::SAMPLE_BITS-1:0] i_sample_z,
    input  logic [ncc_pkg::CLASS_BITS-1:0]  i_true_class,
    input  logic [ncc_pkg::CLASS_BITS-1:0]  i_read_column,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ncc_pkg::CLASS_BITS-1:0]  o_pred_class,
    output logic [ncc_pkg::DIST_BITS-1:0]   o_min_distance_sq,
    output logic [ncc_pkg::COUNT_BITS-1:0]  o_cell_count,
    output logic                            o_bad_class
);
    import ncc_pkg::*;

    t_centroid w_centroid [NUM_CLASSES];
    t_tag      w_tag;
    t_job      w_push_job;
    t_job      w_head_job;
    logic      w_push;
    logic      w_full;
    logic      w_pop;
    logic      w_empty;

    assign w_tag.op  = i_op;
    assign w_tag.row = i_true_class;
    assign w_tag.col = i_read_column;

    ncc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_centroid (w_centroid)
    );

    ncc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_centroid (w_centroid),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_tag      (w_tag),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_sample_z (i_sample_z),
        .o_push     (w_push),
        .i_full     (w_full),
        .o_job      (w_push_job)
    );

    ncc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty)
    );

    ncc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (w_empty),
        .o_pop             (w_pop),
        .i_job             (w_head_job),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_pred_class      (o_pred_class),
        .o_min_distance_sq (o_min_distance_sq),
        .o_cell_count      (o_cell_count),
        .o_bad_class       (o_bad_class)
    );

endmodule

`default_nettype wire

// File: src/ncc_checker.sv
`default_nettype none

`include "nearest_centroid_confusion_counter_assert.svh"

module ncc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [ncc_pkg::CLASS_BITS-1:0]  o_pred_class,
    input  logic [ncc_pkg::DIST_BITS-1:0]   o_min_distance_sq,
    input  logic [ncc_pkg::COUNT_BITS-1:0]  o_cell_count,
    input  logic                            o_bad_class
);
    import ncc_pkg::*;

    `NCC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    `NCC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_cell_count) && $stable(o_min_distance_sq) && $stable(o_pred_class) && $stable(o_bad_class), "result changed while stalled")

    `NCC_ASSERT_NOW(a_bad_no_count, o_out_valid && o_bad_class, o_cell_count == '0, "bad row with nonzero count")

    `NCC_ASSERT_NOW(a_pred_range, o_out_valid, o_pred_class < CLASS_BITS'(NUM_CLASSES), "class index out of range")

endmodule

bind nearest_centroid_confusion_counter ncc_checker u_ncc_checker (.*);

`default_nettype wire
